// File: hdl/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg
// Shared constants, register codes and root table for the gamma pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pgc_pkg;

	localparam int FRAC_BITS   = 30;
	localparam int MANT_W      = FRAC_BITS + 1;
	localparam int GAMMA_W     = 16;
	localparam int GAMMA_FRAC  = 12;
	localparam int MAXV_W      = 8;
	localparam int SHIFT_W     = 6;
	localparam int Q_SAT_HI    = 16;
	localparam int Q_ZERO_LO   = 20;
	localparam int BIAS_POS    = 14;
	localparam int OUT_W       = 40;

	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd4096;
	localparam logic [MAXV_W-1:0]  MAXV_RESET  = 8'd255;

	typedef enum logic [0:0] {
		REG_GAMMA = 1'b0,
		REG_MAXV  = 1'b1
	} cfg_reg_t;

	typedef logic [MANT_W-1:0] mant_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		int          i;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(2^-(k+1)) in Q1.30
	function automatic mant_t root_q(input int k);
		logic [63:0] r;
		int          j;
		r = isqrt64(64'd1 << 61);
		for (j = 1; j < FRAC_BITS; j++) begin
			if (j <= k) r = isqrt64(r << FRAC_BITS);
		end
		return r[MANT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/pgc_log2.sv
// ----------------------------------------------------------------------------
// pgc_log2
// Pipelined fixed-point log2: normalize, then one squaring stage per bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_log2 #(
	parameter int LANES  = 4,
	parameter int IN_W   = 8,
	parameter int SIDE_W = 4,
	localparam int EXP_W = $clog2(IN_W),
	localparam int LOG_W = EXP_W + pgc_pkg::FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][IN_W-1:0]   in_value,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_valid,
	output logic [LANES-1:0][LOG_W-1:0]  out_log,
	output logic [SIDE_W-1:0]            out_side
);
	import pgc_pkg::*;

	localparam int STAGES = FRAC_BITS;

	logic                 valid_s [STAGES+1];
	logic [SIDE_W-1:0]    side_s  [STAGES+1];
	logic [EXP_W-1:0]     exp_s   [STAGES+1][LANES];
	mant_t                mant_s  [STAGES+1][LANES];
	logic [FRAC_BITS-1:0] frac_s  [STAGES+1][LANES];

	logic [EXP_W-1:0] lead [LANES];
	mant_t            norm [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lead[l] = '0;
			for (int b = 0; b < IN_W; b++) begin
				if (in_value[l][b]) lead[l] = EXP_W'(b);
			end
			norm[l] = MANT_W'({in_value[l], {FRAC_BITS{1'b0}}} >> lead[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int l = 0; l < LANES; l++) begin
				exp_s[0][l]  <= lead[l];
				mant_s[0][l] <= norm[l];
				frac_s[0][l] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= STAGES; k++) begin : g_sq
		logic [2*MANT_W-1:0] sq    [LANES];
		logic [MANT_W:0]     top_p [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				sq[l]    = (2*MANT_W)'(mant_s[k-1][l]) * (2*MANT_W)'(mant_s[k-1][l]);
				top_p[l] = sq[l][2*MANT_W-1:FRAC_BITS];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					exp_s[k][l] <= exp_s[k-1][l];
					if (top_p[l][MANT_W]) begin
						mant_s[k][l] <= top_p[l][MANT_W:1];
					end else begin
						mant_s[k][l] <= top_p[l][MANT_W-1:0];
					end
					frac_s[k][l] <= {frac_s[k-1][l][FRAC_BITS-2:0], top_p[l][MANT_W]};
				end
			end
		end
	end

	always_comb begin
		out_valid = valid_s[STAGES];
		out_side  = side_s[STAGES];
		for (int l = 0; l < LANES; l++) begin
			out_log[l] = {exp_s[STAGES][l], frac_s[STAGES][l]};
		end
	end

endmodule

`default_nettype wire

// File: hdl/pgc_expo.sv
// ----------------------------------------------------------------------------
// pgc_expo
// Pipelined exponent scaling, 2^x by root table, scaling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_expo #(
	parameter int LANES        = 3,
	parameter int CHANNEL_BITS = 8,
	parameter int LOG_W        = 33,
	parameter int SIDE_W       = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [LANES-1:0][LOG_W-1:0]         in_lx,
	input  logic [LOG_W-1:0]                    in_lm,
	input  logic [LANES-1:0]                    in_zero,
	input  logic [SIDE_W-1:0]                   in_side,
	input  logic [pgc_pkg::GAMMA_W-1:0]         gamma,
	input  logic [pgc_pkg::MAXV_W-1:0]          max_value,
	output logic                                out_valid,
	output logic [LANES-1:0][CHANNEL_BITS-1:0]  out_y,
	output logic [SIDE_W-1:0]                   out_side
);
	import pgc_pkg::*;

	localparam int T_W   = LOG_W + GAMMA_W - GAMMA_FRAC;
	localparam int IP_W  = T_W - FRAC_BITS;
	localparam int Q_W   = IP_W + 2;
	localparam int P_W   = MAXV_W + MANT_W;
	localparam int CMP_W = (CHANNEL_BITS > MAXV_W) ? CHANNEL_BITS : MAXV_W;
	localparam logic [CHANNEL_BITS-1:0] TOP = {CHANNEL_BITS{1'b1}};

	// stage 1: distance of logs
	logic              valid_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [LANES-1:0]  zero_s1;
	logic [LANES-1:0]  neg_s1;
	logic [LOG_W-1:0]  d_s1 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			zero_s1 <= in_zero;
			for (int l = 0; l < LANES; l++) begin
				neg_s1[l] <= in_lx[l] < in_lm;
				d_s1[l]   <= (in_lx[l] < in_lm) ? in_lm - in_lx[l] : in_lx[l] - in_lm;
			end
		end
	end

	// stage 2: scale by gamma
	logic                     valid_s2;
	logic [SIDE_W-1:0]        side_s2;
	logic [LANES-1:0]         zero_s2;
	logic [LANES-1:0]         neg_s2;
	logic [T_W-1:0]           t_s2 [LANES];
	logic [LOG_W+GAMMA_W-1:0] dg   [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			dg[l] = (LOG_W+GAMMA_W)'(d_s1[l]) * (LOG_W+GAMMA_W)'(gamma);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			zero_s2 <= zero_s1;
			neg_s2  <= neg_s1;
			for (int l = 0; l < LANES; l++) begin
				t_s2[l] <= dg[l][LOG_W+GAMMA_W-1:GAMMA_FRAC];
			end
		end
	end

	// stage 3 (index 0 of the power arrays): split into integer and fraction
	logic                 valid_s [FRAC_BITS+1];
	logic [SIDE_W-1:0]    side_s  [FRAC_BITS+1];
	logic [LANES-1:0]     zero_s  [FRAC_BITS+1];
	logic [LANES-1:0]     hi_s    [FRAC_BITS+1];
	logic [LANES-1:0]     lo_s    [FRAC_BITS+1];
	logic [SHIFT_W-1:0]   sh_s    [FRAC_BITS+1][LANES];
	logic [FRAC_BITS-1:0] fb_s    [FRAC_BITS+1][LANES];
	mant_t                acc_s   [FRAC_BITS+1][LANES];

	logic [IP_W-1:0]       ip   [LANES];
	logic [FRAC_BITS-1:0]  ft   [LANES];
	logic                  nz   [LANES];
	logic signed [Q_W-1:0] qv   [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			ip[l] = t_s2[l][T_W-1:FRAC_BITS];
			ft[l] = t_s2[l][FRAC_BITS-1:0];
			nz[l] = |ft[l];
			if (neg_s2[l]) begin
				qv[l] = -$signed(Q_W'(ip[l]) + Q_W'(nz[l]));
			end else begin
				qv[l] = $signed(Q_W'(ip[l]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s[0] <= 1'b0;
		else if (en) valid_s[0] <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_s2;
			zero_s[0] <= zero_s2;
			for (int l = 0; l < LANES; l++) begin
				hi_s[0][l]  <= qv[l] > $signed(Q_W'(Q_SAT_HI));
				lo_s[0][l]  <= qv[l] < -$signed(Q_W'(Q_ZERO_LO));
				sh_s[0][l]  <= SHIFT_W'(SHIFT_W'(FRAC_BITS) - qv[l][SHIFT_W-1:0]);
				fb_s[0][l]  <= (neg_s2[l] && nz[l]) ? FRAC_BITS'(-ft[l]) : ft[l];
				acc_s[0][l] <= MANT_W'(1) << FRAC_BITS;
			end
		end
	end

	// power stages: one root factor per fraction bit
	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_pw
		localparam mant_t ROOT = root_q(k - 1);
		logic [2*MANT_W-1:0] pr [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				pr[l] = (2*MANT_W)'(acc_s[k-1][l]) * (2*MANT_W)'(ROOT);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[k] <= 1'b0;
			else if (en) valid_s[k] <= valid_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_s[k-1];
				zero_s[k] <= zero_s[k-1];
				hi_s[k]   <= hi_s[k-1];
				lo_s[k]   <= lo_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					sh_s[k][l] <= sh_s[k-1][l];
					fb_s[k][l] <= fb_s[k-1][l];
					if (fb_s[k-1][l][FRAC_BITS-k]) begin
						acc_s[k][l] <= pr[l][FRAC_BITS+MANT_W-1:FRAC_BITS];
					end else begin
						acc_s[k][l] <= acc_s[k-1][l];
					end
				end
			end
		end
	end

	// stage 34: scale by max value
	logic               valid_s34;
	logic [SIDE_W-1:0]  side_s34;
	logic [LANES-1:0]   zero_s34;
	logic [LANES-1:0]   hi_s34;
	logic [LANES-1:0]   lo_s34;
	logic [SHIFT_W-1:0] sh_s34   [LANES];
	logic [P_W-1:0]     prod_s34 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s34 <= 1'b0;
		else if (en) valid_s34 <= valid_s[FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s34 <= side_s[FRAC_BITS];
			zero_s34 <= zero_s[FRAC_BITS];
			hi_s34   <= hi_s[FRAC_BITS];
			lo_s34   <= lo_s[FRAC_BITS];
			for (int l = 0; l < LANES; l++) begin
				sh_s34[l]   <= sh_s[FRAC_BITS][l];
				prod_s34[l] <= P_W'(max_value) * P_W'(acc_s[FRAC_BITS][l]);
			end
		end
	end

	// stage 35: round, shift, saturate, special cases
	logic                    valid_s35;
	logic [SIDE_W-1:0]       side_s35;
	logic [CHANNEL_BITS-1:0] y_s35 [LANES];

	logic [OUT_W-1:0]        bias  [LANES];
	logic [OUT_W-1:0]        vsum  [LANES];
	logic [OUT_W-1:0]        yfull [LANES];
	logic [CHANNEL_BITS-1:0] ysel  [LANES];
	logic [CHANNEL_BITS-1:0] mclip;

	always_comb begin
		mclip = (CMP_W'(max_value) > CMP_W'(TOP)) ? TOP : CHANNEL_BITS'(max_value);
		for (int l = 0; l < LANES; l++) begin
			bias[l]  = OUT_W'(1) << SHIFT_W'(sh_s34[l] - SHIFT_W'(BIAS_POS));
			vsum[l]  = OUT_W'(prod_s34[l]) + bias[l];
			yfull[l] = vsum[l] >> sh_s34[l];
			if (max_value == '0) begin
				ysel[l] = '0;
			end else if (zero_s34[l]) begin
				ysel[l] = (gamma != '0) ? '0 : mclip;
			end else if (hi_s34[l]) begin
				ysel[l] = TOP;
			end else if (lo_s34[l]) begin
				ysel[l] = '0;
			end else if (yfull[l] > OUT_W'(TOP)) begin
				ysel[l] = TOP;
			end else begin
				ysel[l] = yfull[l][CHANNEL_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s35 <= 1'b0;
		else if (en) valid_s35 <= valid_s34;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s35 <= side_s34;
			for (int l = 0; l < LANES; l++) begin
				y_s35[l] <= ysel[l];
			end
		end
	end

	always_comb begin
		out_valid = valid_s35;
		out_side  = side_s35;
		for (int l = 0; l < LANES; l++) begin
			out_y[l] = y_s35[l];
		end
	end

endmodule

`default_nettype wire

// File: hdl/pixel_gamma_correction.sv
// ----------------------------------------------------------------------------
// pixel_gamma_correction
// Power-law gamma correction of an RGB pixel stream.
// ----------------------------------------------------------------------------
// One pixel word enters on the s_axis channel and one corrected word leaves
// on the m_axis channel; tlast carries the end-of-image mark through.
// Each channel becomes floor(M * (x/M)^g), g = gamma_q4_12 / 4096 and
// M = max_value, saturated at the largest channel code.
// Registers are written on the cfg channel (index 0 gamma, 1 max value);
// the user must write them only while no pixel is in flight; the block does
// not enforce it; cfg_ready is always high. Throughput: one pixel per clock
// when not stalled. Pixels pass the 30 squaring stages of the log2 pipeline,
// the 30 root-multiply stages of the power pipeline and staging registers.
// Reset clears all valid bits and loads gamma 1.0 and max value 255.
// When the receiver stalls, the word in the output register holds, one more
// word drops into a skid register, and s_axis_tready falls until the skid
// drains; the pipeline then freezes with every word kept in place.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_gamma_correction #(
	parameter int CHANNEL_BITS = 8,
	localparam int DATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [DATA_W-1:0]           s_axis_tdata,   // red_in, green_in, blue_in
	input  logic                        s_axis_tlast,   // end_of_image
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [DATA_W-1:0]           m_axis_tdata,   // red_out, green_out, blue_out
	output logic                        m_axis_tlast,   // end_of_image_out
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  pgc_pkg::cfg_reg_t           cfg_index,
	input  logic [pgc_pkg::GAMMA_W-1:0] cfg_data
);
	import pgc_pkg::*;

	localparam int IN_W  = (CHANNEL_BITS > MAXV_W) ? CHANNEL_BITS : MAXV_W;
	localparam int LOG_W = $clog2(IN_W) + FRAC_BITS;
	localparam int PIX_W = 3 * CHANNEL_BITS;

	logic [GAMMA_W-1:0] gamma_q;
	logic [MAXV_W-1:0]  maxv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RESET;
			maxv_q  <= MAXV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAMMA: gamma_q <= cfg_data;
				REG_MAXV:  maxv_q  <= cfg_data[MAXV_W-1:0];
				default: ;
			endcase
		end
	end

	logic                               en;
	logic [3:0][IN_W-1:0]               lg_in;
	logic [2:0]                         chan_zero;
	logic                               lg_valid;
	logic [3:0][LOG_W-1:0]              lg_out;
	logic [3:0]                         lg_side;
	logic                               r_valid;
	logic [2:0][CHANNEL_BITS-1:0]       r_y;
	logic                               r_last;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			lg_in[l]     = IN_W'(s_axis_tdata[l*CHANNEL_BITS +: CHANNEL_BITS]);
			chan_zero[l] = s_axis_tdata[l*CHANNEL_BITS +: CHANNEL_BITS] == '0;
		end
		lg_in[3] = IN_W'(maxv_q);
	end

	pgc_log2 #(
		.LANES  (4),
		.IN_W   (IN_W),
		.SIDE_W (4)
	) u_log2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_value  (lg_in),
		.in_side   ({chan_zero, s_axis_tlast}),
		.out_valid (lg_valid),
		.out_log   (lg_out),
		.out_side  (lg_side)
	);

	pgc_expo #(
		.LANES        (3),
		.CHANNEL_BITS (CHANNEL_BITS),
		.LOG_W        (LOG_W),
		.SIDE_W       (1)
	) u_expo (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (lg_valid),
		.in_lx     (lg_out[2:0]),
		.in_lm     (lg_out[3]),
		.in_zero   (lg_side[3:1]),
		.in_side   (lg_side[0]),
		.gamma     (gamma_q),
		.max_value (maxv_q),
		.out_valid (r_valid),
		.out_y     (r_y),
		.out_side  (r_last)
	);

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;
	logic              sk_valid_q;
	logic [DATA_W-1:0] sk_data_q;
	logic              sk_last_q;
	logic [DATA_W-1:0] r_word;

	assign r_word        = DATA_W'(PIX_W'(r_y));
	assign en            = !sk_valid_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (en) begin
			if (out_valid_q && !m_axis_tready) begin
				if (r_valid) sk_valid_q <= 1'b1;
			end else begin
				out_valid_q <= r_valid;
			end
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= 1'b1;
			sk_valid_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_valid_q && !m_axis_tready) begin
				sk_data_q <= r_word;
				sk_last_q <= r_last;
			end else begin
				out_data_q <= r_word;
				out_last_q <= r_last;
			end
		end else if (!out_valid_q || m_axis_tready) begin
			out_data_q <= sk_data_q;
			out_last_q <= sk_last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: hdl/pgc_checker.sv
// ----------------------------------------------------------------------------
// pgc_checker
// Port-level checks of the gamma block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_checker #(
	parameter int CHANNEL_BITS = 8,
	localparam int DATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata,
	input logic              m_axis_tlast
);
	localparam int CAPACITY = 68;
	localparam int CNT_W    = 8;

	logic             in_acc;
	logic             out_acc;
	logic [CNT_W-1:0] pending_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + CNT_W'(1);
		end else if (!in_acc && out_acc) begin
			pending_q <= pending_q - CNT_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != '0)
		else $error("output word without a pending input word");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(CAPACITY))
		else $error("more words in flight than the pipeline holds");

endmodule

bind pixel_gamma_correction pgc_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_pgc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
